FILE: hw/rtl/gtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Graph transitivity check: shared definitions
// Field widths, request codes and the decoded request group that the
// top level hands to the row memory and the edge update stage.
// ----------------------------------------------------------------------------
package gtc_pkg;

   localparam int OP_W     = 2;
   localparam int VERTEX_W = 5;
   localparam int COUNT_W  = 6;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR     = 2'd0,
      OP_ADD_EDGE  = 2'd1,
      OP_QUERY     = 2'd2
   } gtc_op_type;

   typedef struct packed {
      logic clear;
      logic add_edge;
      logic query;
   } gtc_req_decode_type;

endpackage
`default_nettype wire

FILE: hw/rtl/gtc_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency row memory
// One row per vertex, one write and one registered read per cycle. A valid
// flag per row lets a clear empty the whole graph without touching the rows.
// ----------------------------------------------------------------------------
module gtc_row_mem #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic                                   wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]        wr_addr,
   input  logic [MAX_VERTICES-1:0]                wr_data,
   input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
   output logic [MAX_VERTICES-1:0]                rd_row
);
   import gtc_pkg::*;

   logic [MAX_VERTICES-1:0] mem_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         rd_hit_ff <= row_valid_ff[rd_addr];
         if (clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // A row that was never written since the last clear reads as no edges.
   assign rd_row = rd_hit_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/gtc_edge_rmw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edge insert stage
// Reads the source row when an edge request is accepted and writes it back
// with the target bit set in the next cycle. The last written row is forwarded
// so that back-to-back edges on the same row are not lost.
// ----------------------------------------------------------------------------
module gtc_edge_rmw #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gtc_pkg::gtc_req_decode_type            dec,
   input  logic [$clog2(MAX_VERTICES)-1:0]        src_addr,
   input  logic [$clog2(MAX_VERTICES)-1:0]        dst_addr,
   input  logic [MAX_VERTICES-1:0]                rd_row,
   output logic                                   wr_en,
   output logic [$clog2(MAX_VERTICES)-1:0]        wr_addr,
   output logic [MAX_VERTICES-1:0]                wr_data
);
   import gtc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   logic                    s1_valid_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic [AW-1:0]           s1_dst_ff;
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic [MAX_VERTICES-1:0] fwd_data_ff;
   logic [MAX_VERTICES-1:0] base_row;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         base_row = fwd_data_ff;
      end else begin
         base_row = rd_row;
      end
      wr_en   = s1_valid_ff;
      wr_addr = s1_addr_ff;
      wr_data = base_row | (MAX_VERTICES'(1) << s1_dst_ff);
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= src_addr;
      s1_dst_ff   <= dst_addr;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= wr_data;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= dec.add_edge;
         fwd_valid_ff <= s1_valid_ff && !dec.clear;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/gtc_query_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transitivity walk
// For each checked source row, visits every edge to another vertex, reads
// the head's row and tests that it is covered by the source row, until the
// first violation. Holds the verdict in the result register until it is taken.
// ----------------------------------------------------------------------------
module gtc_query_walk #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [gtc_pkg::COUNT_W-1:0]            vertex_count,
   input  logic [MAX_VERTICES-1:0]                rd_row,
   output logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_is_transitive
);
   import gtc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [COUNT_W:0] MAX_COUNT = (COUNT_W + 1)'(MAX_VERTICES);

   typedef enum logic [2:0] {
      W_IDLE,
      W_ROW,
      W_ROW_DATA,
      W_SCAN,
      W_CHECK,
      W_DONE
   } walk_state_type;

   walk_state_type          state_ff, state_in;
   logic [CW-1:0]           i_ff, i_in;
   logic [MAX_VERTICES-1:0] row_i_ff, row_i_in;
   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic                    verdict_ff, verdict_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_data_ff, rsp_data_in;
   logic [COUNT_W:0]        count_ext;
   logic [COUNT_W:0]        n_limit;
   logic [AW-1:0]           j_idx;
   logic [MAX_VERTICES-1:0] self_bit;

   function automatic logic [AW-1:0] lowest_set(input logic [MAX_VERTICES-1:0] v);
      logic [AW-1:0] idx;
      idx = '0;
      for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
         if (v[k]) begin
            idx = AW'(k);
         end
      end
      return idx;
   endfunction

   always_comb begin
      count_ext = {1'b0, vertex_count};
      n_limit   = (count_ext > MAX_COUNT) ? MAX_COUNT : count_ext;
      j_idx     = lowest_set(mask_ff);
      self_bit  = MAX_VERTICES'(1) << AW'(i_ff);

      state_in     = state_ff;
      i_in         = i_ff;
      row_i_in     = row_i_ff;
      mask_in      = mask_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = AW'(i_ff);

      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               i_in     = '0;
               state_in = W_ROW;
            end
         end
         W_ROW: begin
            if ((COUNT_W + 1)'(i_ff) >= n_limit) begin
               verdict_in = 1'b1;
               state_in   = W_DONE;
            end else begin
               state_in = W_ROW_DATA;
            end
         end
         W_ROW_DATA: begin
            row_i_in = rd_row;
            mask_in  = rd_row & ~self_bit;
            state_in = W_SCAN;
         end
         W_SCAN: begin
            rd_addr = j_idx;
            if (mask_ff == '0) begin
               i_in     = i_ff + CW'(1);
               state_in = W_ROW;
            end else begin
               mask_in  = mask_ff & ~(MAX_VERTICES'(1) << j_idx);
               state_in = W_CHECK;
            end
         end
         W_CHECK: begin
            if ((rd_row & ~row_i_ff) != '0) begin
               verdict_in = 1'b0;
               state_in   = W_DONE;
            end else begin
               state_in = W_SCAN;
            end
         end
         W_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = verdict_ff;
               state_in     = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      row_i_ff    <= row_i_in;
      mask_ff     <= mask_in;
      verdict_ff  <= verdict_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= W_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy              = (state_ff != W_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_transitive = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/graph_transitivity_check_top.sv
`default_nettype none
// Clear requests and edge requests can follow each other back to back; an
// edge request runs as a read-modify-write of the source row in the row
// memory, overlapped with the next request. A query holds off further
// requests while it walks the rows through the memory's single read port,
// reading each checked row and then the row at the head of each of its edges
// to other vertices. The walk stops at the first violation found. The
// verdict waits in an output register, and clear and edge requests are taken
// while it waits. A query whose walk ends while the previous verdict still
// waits keeps holding off requests in its done state until that verdict is
// taken.
// ----------------------------------------------------------------------------
// Graph transitivity check top level
// Decodes requests, holds the vertex count register and connects the row
// memory, the edge insert stage and the transitivity walk.
// ----------------------------------------------------------------------------
module graph_transitivity_check_top #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gtc_pkg::OP_W-1:0]         req_op,
   input  logic [gtc_pkg::VERTEX_W-1:0]     req_source_vertex,
   input  logic [gtc_pkg::VERTEX_W-1:0]     req_target_vertex,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_transitive,
   input  logic                             csr_write_enable,
   input  logic [gtc_pkg::COUNT_W-1:0]      csr_write_data
);
   import gtc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   logic [COUNT_W-1:0]      vertex_count_ff;
   logic                    req_accept;
   logic                    in_range;
   gtc_req_decode_type      dec;
   logic [AW-1:0]           src_addr;
   logic [AW-1:0]           dst_addr;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           walk_rd_addr;
   logic [MAX_VERTICES-1:0] rd_row;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [MAX_VERTICES-1:0] wr_data;
   logic                    walk_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         vertex_count_ff <= csr_write_data;
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign in_range   = (int'(req_source_vertex) < MAX_VERTICES) &&
                       (int'(req_target_vertex) < MAX_VERTICES);
   assign src_addr   = AW'(req_source_vertex);
   assign dst_addr   = AW'(req_target_vertex);

   always_comb begin
      dec = '0;
      if (req_accept) begin
         unique case (gtc_op_type'(req_op))
            OP_CLEAR:    dec.clear    = 1'b1;
            OP_ADD_EDGE: dec.add_edge = in_range;
            OP_QUERY:    dec.query    = 1'b1;
            default:     dec          = '0;
         endcase
      end
   end

   assign rd_addr   = walk_busy ? walk_rd_addr : src_addr;
   assign req_stall = walk_busy;

   gtc_row_mem #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (dec.clear),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   gtc_edge_rmw #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_edge_rmw (
      .clock    (clock),
      .reset    (reset),
      .dec      (dec),
      .src_addr (src_addr),
      .dst_addr (dst_addr),
      .rd_row   (rd_row),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   gtc_query_walk #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_query_walk (
      .clock             (clock),
      .reset             (reset),
      .start             (dec.query),
      .vertex_count      (vertex_count_ff),
      .rd_row            (rd_row),
      .rd_addr           (walk_rd_addr),
      .busy              (walk_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_transitive (rsp_is_transitive)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/gtc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Graph transitivity check port checker
// Watches the top level's ports for request flow and result behavior.
// ----------------------------------------------------------------------------
module gtc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [gtc_pkg::OP_W-1:0]         req_op,
   input logic [gtc_pkg::VERTEX_W-1:0]     req_source_vertex,
   input logic [gtc_pkg::VERTEX_W-1:0]     req_target_vertex,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_is_transitive,
   input logic                             csr_write_enable,
   input logic [gtc_pkg::COUNT_W-1:0]      csr_write_data
);
   import gtc_pkg::*;

   // Only a query keeps the block busy.
   a_non_query_no_stall : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op != OP_QUERY)) |=> !req_stall)
      else $error("request stalled after a non-query request");

   // An accepted query always starts the walk, so requests stall in the next cycle.
   a_query_stalls : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op == OP_QUERY)) |=> req_stall)
      else $error("query accepted without the walk starting");

   // A new result only comes out of a running walk.
   a_result_from_walk : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a query in progress");

   // A stalled result keeps its verdict.
   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_is_transitive)))
      else $error("stalled result changed or dropped");

endmodule

bind graph_transitivity_check_top gtc_checker u_gtc_checker (.*);
`default_nettype wire
